>>> rtl/ffd_pkg.sv
// Shared types, codes and helper functions for the farbfeld stream decoder.
// Used by the parser, the result queue and the top level; no dependencies.
package ffd_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_MAGIC  = 2'd0,
    PH_DIMS   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  // Result kinds as seen on the output channel
  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_HEADER    = 3'd1,
    KIND_BAD_MAGIC = 3'd2,
    KIND_END_OK    = 3'd3,
    KIND_END_ERROR = 3'd4
  } kind_t;

  // Magic, dimension block and pixel are all eight bytes long
  localparam int                     GROUP_LEN  = 8;
  localparam logic [2:0]             POS_LAST   = 3'(GROUP_LEN - 1);
  localparam logic [8*GROUP_LEN-1:0] MAGIC_TEXT = "farbfeld";

  // Result queue depth; a byte produces at most two results
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [31:0] pixel_argb;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic        last_of_run;
  } result_t;

  // Results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  // Magic byte expected at a position, first character in the top byte
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    return MAGIC_TEXT[8*(int'(POS_LAST) - int'(pos)) +: 8];
  endfunction

  // floor(v/257): v>>8 is either the quotient or one too high
  function automatic logic [7:0] scale_channel(input logic [15:0] v);
    logic [7:0]  q0;
    logic [15:0] back;
    q0   = v[15:8];
    back = {q0, 8'h00} + {8'h00, q0};
    return (back > v) ? q0 - 8'd1 : q0;
  endfunction

  function automatic result_t make_result(input kind_t kind, input logic [31:0] argb,
                                          input logic [31:0] w, input logic [31:0] h);
    result_t r;
    r.kind         = kind;
    r.pixel_argb   = argb;
    r.image_width  = w;
    r.image_height = h;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/ffd_byte_if.sv
// Byte input channel of the farbfeld stream decoder: valid/ready plus payload.
// Standalone, no package dependency.
interface ffd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

>>> rtl/ffd_result_if.sv
// Result output channel of the farbfeld stream decoder: valid/ready plus payload.
// Standalone, no package dependency.
interface ffd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] pixel_argb;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic        last_of_run;

  modport source (output valid, kind, pixel_argb, image_width, image_height, last_of_run,
                  input ready);
  modport sink   (input valid, kind, pixel_argb, image_width, image_height, last_of_run,
                  output ready);
endinterface

>>> rtl/ffd_parser.sv
// Byte parser: magic check, header capture, pixel assembly and end-of-file status.
// Depends on ffd_pkg; produces up to two results per accepted byte.
module ffd_parser import ffd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [2:0]  pos, pos_next;
  logic        magic_matched, magic_matched_next;
  logic [31:0] width_reg, width_next;
  logic [31:0] height_reg, height_next;
  logic [63:0] pixels_left, pixels_left_next;
  logic        pixels_excess, pixels_excess_next;
  logic [7:0]  pending_high_byte, pending_next;
  logic [23:0] partial_channels, partial_next;

  logic [31:0] height_shift;
  logic [7:0]  chan;
  logic        header_zero;
  kind_t       end_kind;

  assign height_shift = {height_reg[23:0], data_byte};
  assign chan         = scale_channel({pending_high_byte, data_byte});
  assign header_zero  = (width_reg == 32'd0) || (height_shift == 32'd0);

  // Next state and results for the byte on the input
  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    magic_matched_next = magic_matched;
    width_next         = width_reg;
    height_next        = height_reg;
    pixels_left_next   = pixels_left;
    pixels_excess_next = pixels_excess;
    pending_next       = pending_high_byte;
    partial_next       = partial_channels;
    push               = '0;
    end_kind           = KIND_END_ERROR;

    if (accept) begin
      case (phase)
        PH_MAGIC: begin
          magic_matched_next = magic_matched && (data_byte == magic_byte(pos));
          pos_next           = pos + 3'd1;
          if (pos == POS_LAST) begin
            if (magic_matched_next) begin
              phase_next = PH_DIMS;
              if (final_byte) begin
                push.first = make_result(KIND_END_ERROR, '0, '0, '0);
                push.num   = 2'd1;
              end
            end else begin
              phase_next = PH_IGNORE;
              push.first = make_result(KIND_BAD_MAGIC, '0, '0, '0);
              push.num   = 2'd1;
            end
          end else if (final_byte) begin
            push.first = make_result(KIND_END_ERROR, '0, '0, '0);
            push.num   = 2'd1;
          end
        end
        PH_DIMS: begin
          if (!pos[2]) begin
            width_next = {width_reg[23:0], data_byte};
          end else begin
            height_next = height_shift;
          end
          pos_next = pos + 3'd1;
          if (pos == POS_LAST) begin
            phase_next         = PH_PIXELS;
            pixels_left_next   = 64'(width_reg) * 64'(height_shift);
            pixels_excess_next = 1'b0;
            push.first         = make_result(KIND_HEADER, '0, width_reg, height_shift);
            push.num           = 2'd1;
            if (final_byte) begin
              end_kind    = header_zero ? KIND_END_OK : KIND_END_ERROR;
              push.second = make_result(end_kind, '0, '0, '0);
              push.num    = 2'd2;
            end
          end else if (final_byte) begin
            push.first = make_result(KIND_END_ERROR, '0, '0, '0);
            push.num   = 2'd1;
          end
        end
        PH_PIXELS: begin
          if (!pos[0]) begin
            pending_next = data_byte;
          end else if (pos != POS_LAST) begin
            partial_next = {partial_channels[15:0], chan};
          end else if (pixels_left == 64'd0) begin
            pixels_excess_next = 1'b1;
          end else begin
            pixels_left_next = pixels_left - 64'd1;
            push.first       = make_result(KIND_PIXEL, {chan, partial_channels}, '0, '0);
            push.num         = 2'd1;
          end
          pos_next = pos + 3'd1;
          if (final_byte) begin
            end_kind = (pixels_left_next == 64'd0 && !pixels_excess_next) ?
                       KIND_END_OK : KIND_END_ERROR;
            if (push.num == 2'd0) begin
              push.first = make_result(end_kind, '0, '0, '0);
              push.num   = 2'd1;
            end else begin
              push.second = make_result(end_kind, '0, '0, '0);
              push.num    = 2'd2;
            end
          end
        end
        default: begin
          // bytes after a bad magic are dropped
        end
      endcase

      // the last byte of a file returns everything to the start
      if (final_byte) begin
        phase_next         = PH_MAGIC;
        pos_next           = 3'd0;
        magic_matched_next = 1'b1;
        width_next         = '0;
        height_next        = '0;
        pixels_left_next   = '0;
        pixels_excess_next = 1'b0;
        pending_next       = '0;
        partial_next       = '0;
      end
    end

    // mark the last result of this byte
    if (push.num == 2'd1) begin
      push.first.last_of_run = 1'b1;
    end else if (push.num == 2'd2) begin
      push.second.last_of_run = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_MAGIC;
      pos               <= 3'd0;
      magic_matched     <= 1'b1;
      width_reg         <= '0;
      height_reg        <= '0;
      pixels_left       <= '0;
      pixels_excess     <= 1'b0;
      pending_high_byte <= '0;
      partial_channels  <= '0;
    end else begin
      phase             <= phase_next;
      pos               <= pos_next;
      magic_matched     <= magic_matched_next;
      width_reg         <= width_next;
      height_reg        <= height_next;
      pixels_left       <= pixels_left_next;
      pixels_excess     <= pixels_excess_next;
      pending_high_byte <= pending_next;
      partial_channels  <= partial_next;
    end
  end

  // A final byte always leaves the parser at the start of a new file
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte |=> phase == PH_MAGIC && pos == 3'd0 && magic_matched)
    else $error("parser did not restart after final byte");

  // Results only come from an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd0 |-> accept)
    else $error("results produced without an accepted byte");

  // Two results only at the end of a file
  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 || push.num == 2'd3 |-> final_byte && push.num == 2'd2)
    else $error("bad result count for byte");

  // Exactly one last-of-run flag, on the final result
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 |-> push.second.last_of_run && !push.first.last_of_run)
    else $error("last_of_run misplaced");

endmodule

>>> rtl/ffd_result_fifo.sv
// Result queue between the parser and the output channel; takes up to two
// results per cycle and hands out one per pop. Depends on ffd_pkg.
module ffd_result_fifo import ffd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output result_t head,
  output logic    head_valid,
  input  logic    pop
);

  localparam int             CW         = FIFO_AW + 1;
  localparam logic [CW-1:0]  ROOM_LIMIT = CW'(FIFO_DEPTH - 2);
  localparam logic [CW-1:0]  DEPTH_MAX  = CW'(FIFO_DEPTH);

  result_t             store [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr;
  logic [FIFO_AW-1:0]  rptr;
  logic [CW-1:0]       count;
  logic                pop_fire;

  assign room       = count <= ROOM_LIMIT;
  assign head_valid = count != '0;
  assign head       = store[rptr];
  assign pop_fire   = pop && head_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(push.num);
      rptr  <= rptr + FIFO_AW'(pop_fire);
      count <= count + CW'(push.num) - CW'(pop_fire);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      store[wptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      store[wptr + FIFO_AW'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_MAX)
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    push.num != 2'd0 |-> room)
    else $error("results pushed without two free entries");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    count == CW'(1) && pop_fire && push.num == 2'd0 |=> !head_valid)
    else $error("queue not empty after last item left");

endmodule

>>> rtl/farbfeld_stream_decoder.sv
// farbfeld stream decoder: takes one file byte per cycle while the result queue has
// room and emits header, pixel (ARGB8888) and end-of-file status items. Depends on
// ffd_pkg, ffd_byte_if, ffd_result_if, ffd_parser and ffd_result_fifo.
//
// Usage: feed the file on stream, one byte per item, with final_byte set on the
// last one. A byte is taken every cycle outside reset as long as the four-entry
// result queue has two free entries; results are registered into that queue and
// leave on the result channel in order. Most bytes cause zero or one result; a
// final byte that also completes the header or a pixel causes two, which leave
// one at a time, so sustained input runs at one byte per cycle when the result
// side keeps up. A bad magic gives one bad-magic item and then bytes are dropped
// until the final byte, which ends that file silently. After every final byte the
// decoder is back at the start of a new file.
module farbfeld_stream_decoder import ffd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ffd_byte_if.sink            stream,
  ffd_result_if.source        result
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;
  logic    head_valid;

  assign stream.ready = room && !rst;
  assign accept       = stream.valid && stream.ready;

  ffd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (stream.data_byte),
    .final_byte (stream.final_byte),
    .push       (push)
  );

  ffd_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head       (head),
    .head_valid (head_valid),
    .pop        (result.ready)
  );

  // Output channel
  assign result.valid        = head_valid;
  assign result.kind         = head.kind;
  assign result.pixel_argb   = head.pixel_argb;
  assign result.image_width  = head.image_width;
  assign result.image_height = head.image_height;
  assign result.last_of_run  = head.last_of_run;

endmodule
